FILE: sv/rgbxy_pkg.sv
// Package: widths, matrix coefficients and linearisation table for the RGB to xy converter.
package rgbxy_pkg;

    localparam int CHAN_W     = 8;
    localparam int LIN_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PRD_W      = LIN_W + COEF_W;
    localparam int XYZ_W      = PRD_W + 2;
    localparam int SUM_W      = XYZ_W + 2;
    localparam int OUT_W      = 16;
    localparam int FRAC_BITS  = 16;
    localparam int FRONT_STG  = 4;
    localparam int N_STG      = FRONT_STG + FRAC_BITS;
    localparam int LIN_SIZE   = 1 << CHAN_W;

    localparam logic [63:0] ONE30    = 64'd1 << 30;
    localparam logic [63:0] LIN_DIV  = 64'd269025;
    localparam logic [63:0] LOW_DIV  = 64'd32946;
    localparam logic [63:0] LOW_HALF = 64'd16473;

    typedef logic [LIN_SIZE-1:0][LIN_W-1:0]        t_lin_tab;
    typedef logic [2:0][2:0][COEF_W-1:0]           t_coef;
    typedef logic [2:0][LIN_W-1:0]                 t_lin3;

    // rows X, Y, Z; columns red, green, blue
    localparam t_coef COEF = '{
        '{16'd64621, 16'd4739,  16'd6},
        '{16'd3125,  16'd43806, 16'd18604},
        '{16'd10619, 16'd10114, 16'd43549}
    };

    function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    function automatic logic [63:0] pow5_30(input logic [63:0] r);
        logic [63:0] p;
        p = mul30(r, r);
        p = mul30(p, r);
        p = mul30(p, r);
        return mul30(p, r);
    endfunction

    function automatic logic [LIN_W-1:0] lin_entry(input logic [63:0] c);
        logic [63:0] q;
        logic [63:0] w;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] l;
        logic [63:0] e;
        if (c * 64'd100000 <= 64'd1031475) begin
            e = (c * 64'd5 * 64'd65536 * 64'd2 + LOW_HALF) / LOW_DIV;
            return e[LIN_W-1:0];
        end
        q  = ((c * 64'd1000 + 64'd14025) << 30) / LIN_DIV;
        w  = mul30(q, q);
        lo = 64'd0;
        hi = ONE30;
        for (int k = 0; k < 40; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow5_30(mid) <= w) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        l = mul30(w, lo);
        e = (l + (64'd1 << 13)) >> 14;
        if (e > 64'd65535) begin
            e = 64'd65535;
        end
        return e[LIN_W-1:0];
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab t;
        for (int c = 0; c < LIN_SIZE; c++) begin
            t[c] = lin_entry(64'(c));
        end
        return t;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

FILE: sv/rgbxy_lin.sv
// Linearisation stage: sRGB transfer table lookup for the three channels.
module rgbxy_lin (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rgbxy_pkg::CHAN_W-1:0]   i_red,
    input  logic [rgbxy_pkg::CHAN_W-1:0]   i_green,
    input  logic [rgbxy_pkg::CHAN_W-1:0]   i_blue,
    output rgbxy_pkg::t_lin3               o_lin
);

    rgbxy_pkg::t_lin3 r_lin;
    rgbxy_pkg::t_lin3 n_lin;

    always_comb begin
        n_lin[0] = rgbxy_pkg::LIN_TAB[i_red];
        n_lin[1] = rgbxy_pkg::LIN_TAB[i_green];
        n_lin[2] = rgbxy_pkg::LIN_TAB[i_blue];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin <= n_lin;
        end
    end

    assign o_lin = r_lin;

endmodule

FILE: sv/rgbxy_mat.sv
// Matrix stages: products, X Y Z row sums and the chromaticity denominator.
module rgbxy_mat (
    input  logic                          i_clk,
    input  logic [2:0]                    i_en,
    input  rgbxy_pkg::t_lin3              i_lin,
    output logic [rgbxy_pkg::XYZ_W-1:0]   o_num_x,
    output logic [rgbxy_pkg::XYZ_W-1:0]   o_num_y,
    output logic [rgbxy_pkg::SUM_W-1:0]   o_den
);

    logic [rgbxy_pkg::PRD_W-1:0] r_prd [3][3];
    logic [rgbxy_pkg::XYZ_W-1:0] r_xyz [3];
    logic [rgbxy_pkg::XYZ_W-1:0] r_num_x;
    logic [rgbxy_pkg::XYZ_W-1:0] r_num_y;
    logic [rgbxy_pkg::SUM_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prd[i][j] <= rgbxy_pkg::PRD_W'(i_lin[j] * rgbxy_pkg::COEF[i][j]);
                end
            end
        end
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_xyz[i] <= rgbxy_pkg::XYZ_W'(r_prd[i][0])
                          + rgbxy_pkg::XYZ_W'(r_prd[i][1])
                          + rgbxy_pkg::XYZ_W'(r_prd[i][2]);
            end
        end
        if (i_en[2]) begin
            r_num_x <= r_xyz[0];
            r_num_y <= r_xyz[1];
            r_den   <= rgbxy_pkg::SUM_W'(r_xyz[0]) + rgbxy_pkg::SUM_W'(r_xyz[1])
                     + rgbxy_pkg::SUM_W'(r_xyz[2]);
        end
    end

    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_den   = r_den;

endmodule

FILE: sv/rgbxy_div.sv
// Divider pipeline: one restoring quotient bit per stage for x and y.
module rgbxy_div (
    input  logic                             i_clk,
    input  logic [rgbxy_pkg::FRAC_BITS-1:0]  i_en,
    input  logic [rgbxy_pkg::XYZ_W-1:0]      i_num_x,
    input  logic [rgbxy_pkg::XYZ_W-1:0]      i_num_y,
    input  logic [rgbxy_pkg::SUM_W-1:0]      i_den,
    output logic                             o_valid_res,
    output logic [rgbxy_pkg::OUT_W-1:0]      o_x_chroma,
    output logic [rgbxy_pkg::OUT_W-1:0]      o_y_chroma
);

    localparam int NS = rgbxy_pkg::FRAC_BITS;
    localparam int RW = rgbxy_pkg::SUM_W;
    localparam int QW = rgbxy_pkg::FRAC_BITS;

    logic [RW-1:0] r_rem_x [NS];
    logic [RW-1:0] r_rem_y [NS];
    logic [QW-1:0] r_q_x   [NS];
    logic [QW-1:0] r_q_y   [NS];
    logic [RW-1:0] r_den   [NS];
    logic          r_sat_x [NS];
    logic          r_sat_y [NS];

    logic [RW-1:0] w_rem_x [NS];
    logic [RW-1:0] w_rem_y [NS];
    logic [QW-1:0] w_q_x   [NS];
    logic [QW-1:0] w_q_y   [NS];
    logic [RW-1:0] w_den   [NS];
    logic          w_sat_x [NS];
    logic          w_sat_y [NS];

    always_comb begin
        w_rem_x[0] = RW'(i_num_x);
        w_rem_y[0] = RW'(i_num_y);
        w_q_x[0]   = '0;
        w_q_y[0]   = '0;
        w_den[0]   = i_den;
        w_sat_x[0] = RW'(i_num_x) >= i_den;
        w_sat_y[0] = RW'(i_num_y) >= i_den;
        for (int s = 1; s < NS; s++) begin
            w_rem_x[s] = r_rem_x[s-1];
            w_rem_y[s] = r_rem_y[s-1];
            w_q_x[s]   = r_q_x[s-1];
            w_q_y[s]   = r_q_y[s-1];
            w_den[s]   = r_den[s-1];
            w_sat_x[s] = r_sat_x[s-1];
            w_sat_y[s] = r_sat_y[s-1];
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_step
        logic [RW:0] w_r2_x;
        logic [RW:0] w_r2_y;
        logic        w_ge_x;
        logic        w_ge_y;

        always_comb begin
            w_r2_x = {w_rem_x[s], 1'b0};
            w_r2_y = {w_rem_y[s], 1'b0};
            w_ge_x = w_r2_x >= {1'b0, w_den[s]};
            w_ge_y = w_r2_y >= {1'b0, w_den[s]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem_x[s] <= w_ge_x ? RW'(w_r2_x - {1'b0, w_den[s]}) : RW'(w_r2_x);
                r_rem_y[s] <= w_ge_y ? RW'(w_r2_y - {1'b0, w_den[s]}) : RW'(w_r2_y);
                r_q_x[s]   <= {w_q_x[s][QW-2:0], w_ge_x};
                r_q_y[s]   <= {w_q_y[s][QW-2:0], w_ge_y};
                r_den[s]   <= w_den[s];
                r_sat_x[s] <= w_sat_x[s];
                r_sat_y[s] <= w_sat_y[s];
            end
        end
    end

    always_comb begin
        o_valid_res = r_den[NS-1] != '0;
        o_x_chroma  = '0;
        o_y_chroma  = '0;
        if (o_valid_res) begin
            o_x_chroma = r_sat_x[NS-1] ? '1 : rgbxy_pkg::OUT_W'(r_q_x[NS-1]);
            o_y_chroma = r_sat_y[NS-1] ? '1 : rgbxy_pkg::OUT_W'(r_q_y[NS-1]);
        end
    end

endmodule

FILE: sv/rgb_to_xy_chromaticity.sv
// Top level: sRGB triple to CIE xy chromaticity, streaming pipeline.
//
// Input channel (s): one transfer carries an 8-bit red, green, blue triple.
// Output channel (m): one transfer per input carries x and y as unsigned
// 0.16 fractions in tdata and a valid flag in tuser; the flag is low and
// x, y are zero for an all-black triple.
// Pipeline from input transfer to output valid: one table lookup stage,
// three matrix stages (products, row sums, total) and sixteen divider
// stages, one quotient bit per stage.
// Throughput: one triple per clock while the receiver keeps up; the divider stages set the depth.
// Reset (synchronous, active low) empties the pipeline; no output is shown
// until a new input is taken.
// When the receiver stalls, the result holds on the output and each stage
// keeps taking data while any stage ahead of it is empty, so bubbles fill
// before the input side is held off. Results leave in input order.
module rgb_to_xy_chromaticity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // x_chroma [15:0], y_chroma [31:16]
    output logic [0:0]  o_m_tuser    // valid_res [0]
);

    localparam int NS = rgbxy_pkg::N_STG;
    localparam int FS = rgbxy_pkg::FRONT_STG;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;

    rgbxy_pkg::t_lin3                w_lin;
    logic [rgbxy_pkg::XYZ_W-1:0]     w_num_x;
    logic [rgbxy_pkg::XYZ_W-1:0]     w_num_y;
    logic [rgbxy_pkg::SUM_W-1:0]     w_den;
    logic                            w_valid_res;
    logic [rgbxy_pkg::OUT_W-1:0]     w_x_chroma;
    logic [rgbxy_pkg::OUT_W-1:0]     w_y_chroma;

    assign w_en[NS] = i_m_tready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = ~r_vld[k] | w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    rgbxy_lin u_lin (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_lin   (w_lin)
    );

    rgbxy_mat u_mat (
        .i_clk   (i_clk),
        .i_en    (w_en[FS-1:1]),
        .i_lin   (w_lin),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den)
    );

    rgbxy_div u_div (
        .i_clk       (i_clk),
        .i_en        (w_en[NS-1:FS]),
        .i_num_x     (w_num_x),
        .i_num_y     (w_num_y),
        .i_den       (w_den),
        .o_valid_res (w_valid_res),
        .o_x_chroma  (w_x_chroma),
        .o_y_chroma  (w_y_chroma)
    );

    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = {w_y_chroma, w_x_chroma};
    assign o_m_tuser  = w_valid_res;

endmodule

FILE: sv/rgbxy_chk.sv
// Checker: port-level properties of the RGB to xy converter, bound to the top level.
module rgbxy_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_black_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == 32'd0))
        else $error("black result carries nonzero chromaticity");

    a_xy_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, o_m_tdata[15:0]} + {1'b0, o_m_tdata[31:16]} <= 17'h10000))
        else $error("x plus y exceeds one");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");

    a_idle_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input held off with output empty");

endmodule

bind rgb_to_xy_chromaticity rgbxy_chk u_rgbxy_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/rgb_to_xy_chromaticity_tb.sv
// Testbench: streams RGB triples through the chromaticity converter and checks each xy result.
module rgb_to_xy_chromaticity_tb;

    localparam int CW           = rgbxy_pkg::CHAN_W;
    localparam int OW           = rgbxy_pkg::OUT_W;
    localparam int XY_FRAC      = 16;
    localparam int N_RANDOM     = 1850;
    localparam int DRAIN_CYCLES = 2 * rgbxy_pkg::N_STG;
    localparam int MAX_PRINTS   = 40;
    localparam int N_DIRECTED   = 18;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef struct packed {
        logic          valid;
        logic [OW-1:0] x;
        logic [OW-1:0] y;
    } chroma_t;

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        logic          typed;
        logic          valid;
        logic [OW-1:0] x;
        logic [OW-1:0] y;
    } stim_row_t;

    // rows X, Y, Z; columns red, green, blue
    localparam logic [15:0] RGB_TO_XYZ [3][3] = '{
        '{16'd43549, 16'd10114, 16'd10619},
        '{16'd18604, 16'd43806, 16'd3125},
        '{16'd6,     16'd4739,  16'd64621}
    };

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 16'd0, 16'd0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd1,   8'd0,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd1,   8'd0,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd0,   8'd1,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd10,  8'd10,  8'd10,  1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd11,  8'd11,  8'd11,  1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd10,  8'd11,  8'd12,  1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd170, 8'd85,  8'd170, 1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd85,  8'd170, 8'd85,  1'b0, 1'b0, 16'd0, 16'd0},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 16'd0, 16'd0}
    };

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    logic [15:0] srgb_lin [256];
    chroma_t     chroma_due [$];
    int          errors = 0;

    rgb_to_xy_chromaticity DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic chroma_t predict_chroma(input logic [CW-1:0] r, g, b);
        logic [63:0] lin [3];
        logic [63:0] xyz [3];
        logic [63:0] total;
        logic [63:0] qx;
        logic [63:0] qy;
        chroma_t     res;
        lin[0] = 64'(srgb_lin[r]);
        lin[1] = 64'(srgb_lin[g]);
        lin[2] = 64'(srgb_lin[b]);
        for (int i = 0; i < 3; i++) begin
            xyz[i] = lin[0] * 64'(RGB_TO_XYZ[i][0]) + lin[1] * 64'(RGB_TO_XYZ[i][1])
                   + lin[2] * 64'(RGB_TO_XYZ[i][2]);
        end
        total = xyz[0] + xyz[1] + xyz[2];
        res   = '0;
        if (total != 64'd0) begin
            qx        = (xyz[0] << XY_FRAC) / total;
            qy        = (xyz[1] << XY_FRAC) / total;
            res.valid = 1'b1;
            res.x     = (qx > 64'hFFFF) ? 16'hFFFF : qx[15:0];
            res.y     = (qy > 64'hFFFF) ? 16'hFFFF : qy[15:0];
        end
        return res;
    endfunction

    function automatic int pick_gap(input bit calm);
        int n;
        n = $urandom_range(0, 99);
        if (calm || n < 60) begin
            return 0;
        end else if (n < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic send_triple(input logic [CW-1:0] r, g, b, input bit typed,
                               input chroma_t want, input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        chroma_due.push_back(typed ? want : predict_chroma(r, g, b));
    endtask

    initial begin : stimulus
        logic [63:0]   q;
        logic [63:0]   w;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   mid;
        logic [63:0]   p;
        logic [63:0]   e;
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        stim_row_t     row;
        int            n;
        // linear segment below the knee; above it, the squared value times its fifth root
        for (int c = 0; c < 256; c++) begin
            if (c * 100000 <= 1031475) begin
                e = (64'(c) * 64'd655360 + 64'd16473) / 64'd32946;
            end else begin
                q  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
                w  = (q * q) >> 30;
                lo = 64'd0;
                hi = Q30_ONE;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 64'd1) / 64'd2;
                    p   = (mid * mid) >> 30;
                    p   = (p * mid) >> 30;
                    p   = (p * mid) >> 30;
                    p   = (p * mid) >> 30;
                    if (p <= w) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                e = (((w * lo) >> 30) + 64'd8192) >> 14;
            end
            srgb_lin[c] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED[k];
            send_triple(row.r, row.g, row.b, row.typed, {row.valid, row.x, row.y}, 1'b0);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            n = $urandom_range(0, 99);
            r = CW'($urandom_range(0, 255));
            g = CW'($urandom_range(0, 255));
            b = CW'($urandom_range(0, 255));
            if (n < 4) begin
                r = '0;
                g = '0;
                b = '0;
            end else if (n < 20) begin
                if ($urandom_range(0, 1) == 1) r = '0;
                if ($urandom_range(0, 1) == 1) g = '0;
                if ($urandom_range(0, 1) == 1) b = '0;
            end else if (n < 35) begin
                r = CW'($urandom_range(0, 15));
                g = CW'($urandom_range(0, 15));
                b = CW'($urandom_range(0, 15));
            end
            send_triple(r, g, b, 1'b0, '0, ((k / 100) % 3) == 2);
        end
        s_tvalid <= 1'b0;

        while (chroma_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : result_sink
        chroma_t got;
        chroma_t want;
        int      stall;
        int      cycles;
        stall  = 0;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[15:0], m_tdata[31:16]};
                if (chroma_due.size() == 0) begin
                    report_mismatch($sformatf("transfer with nothing due, data %h user %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = chroma_due.pop_front();
                    if (got.valid !== want.valid) begin
                        report_mismatch($sformatf("valid_res %b, due %b", got.valid, want.valid));
                    end
                    if (got.x !== want.x) begin
                        report_mismatch($sformatf("x_chroma %h, due %h", got.x, want.x));
                    end
                    if (got.y !== want.y) begin
                        report_mismatch($sformatf("y_chroma %h, due %h", got.y, want.y));
                    end
                end
            end
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else begin
                if (stall == 0) begin
                    stall = pick_gap(((cycles / 256) % 3) == 1);
                end
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    stall--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: filelist.f
sv/rgbxy_pkg.sv
sv/rgbxy_lin.sv
sv/rgbxy_mat.sv
sv/rgbxy_div.sv
sv/rgb_to_xy_chromaticity.sv
sv/rgbxy_chk.sv
tb/rgb_to_xy_chromaticity_tb.sv
